>>> rtl/core/cwc_pkg.sv
`default_nettype none

package cwc_pkg;

    // default sizes
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int CODE_BITS_DEF   = 16;

    // fixed field widths
    localparam int GROUP_BITS     = 8;
    localparam int INDEX_BITS     = 8;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 8;
    localparam int VERDICT_BITS   = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_USE_PRECEDENCE = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNKNOWN_CODE   = 1'd1;

    // decision and verdict codes
    localparam logic [VERDICT_BITS-1:0] DEC_LESS    = 2'd0;
    localparam logic [VERDICT_BITS-1:0] DEC_EQUAL   = 2'd1;
    localparam logic [VERDICT_BITS-1:0] DEC_GREATER = 2'd2;

    // per-step control bits travelling with an item
    typedef struct packed {
        logic has_a;
        logic has_b;
        logic last;
    } step_ctl_t;

    // order code from less-than / greater-than flags
    function automatic logic [VERDICT_BITS-1:0] order_code(input logic lt, input logic gt);
        logic [VERDICT_BITS-1:0] res;
        if (lt)
        begin
            res = DEC_LESS;
        end
        else if (gt)
        begin
            res = DEC_GREATER;
        end
        else
        begin
            res = DEC_EQUAL;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/collation_word_compare.sv
`default_nettype none

// two-level collation compare of two words streamed one character pair per item.
// an item with func 0 loads one entry of the group table; an item with func 1 is
// one compare step and, when last is set, yields one result item carrying the
// verdict (0 first less, 1 equal, 2 first greater). in precedence mode codes are
// clamped to unknown_code and mapped through the group table: the first group
// difference decides, then the shorter word is less, then the first raw code
// difference. without precedence the first raw difference decides, then length.
// a table entry must be written before a compare step reads it. the block takes
// one item every cycle unless stage 1 is held. an accepted item is loaded into
// stage 1 and its two group table reads are registered at the accepting edge;
// the decision update and the result capture happen when stage 1 fires.
// a full result register that is not drained holds a closing step in stage 1 and
// with it the item input. configuration must be written only while the block is
// idle; the block does not enforce this. cfg_ready is always high.
module collation_word_compare #(
    parameter int TABLE_DEPTH = cwc_pkg::TABLE_DEPTH_DEF,
    parameter int CODE_BITS   = cwc_pkg::CODE_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // configuration write channel
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [cwc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [cwc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    // item channel
    input  wire logic                                  item_valid,
    output logic                                       item_ready,
    input  wire logic                                  func,
    input  wire logic [cwc_pkg::INDEX_BITS-1:0]        table_index,
    input  wire logic [cwc_pkg::GROUP_BITS-1:0]        table_group,
    input  wire logic [CODE_BITS-1:0]                  code_a,
    input  wire logic                                  has_a,
    input  wire logic [CODE_BITS-1:0]                  code_b,
    input  wire logic                                  has_b,
    input  wire logic                                  last,
    // result channel
    output logic                                       result_valid,
    input  wire logic                                  result_ready,
    output logic      [cwc_pkg::VERDICT_BITS-1:0]      verdict
);

    localparam int ADDR_BITS = $clog2(TABLE_DEPTH);

    // configuration registers
    logic use_prec_reg;
    logic [cwc_pkg::CFG_DATA_BITS-1:0] unknown_code_reg;

    // stage 1: item held while its table read completes
    logic s1_valid_reg, s1_valid_next;
    logic s1_func_reg;
    cwc_pkg::step_ctl_t s1_ctl_reg;
    logic [CODE_BITS-1:0] s1_code_a_reg;
    logic [CODE_BITS-1:0] s1_code_b_reg;

    // result register
    logic result_valid_reg, result_valid_next;
    logic [cwc_pkg::VERDICT_BITS-1:0] verdict_reg;

    logic item_accept;
    logic s1_produce, s1_go, s1_fire;
    logic out_free;
    logic [cwc_pkg::GROUP_BITS-1:0] clamp_a, clamp_b;
    logic [ADDR_BITS-1:0] rd_addr_a, rd_addr_b, wr_addr;
    logic [cwc_pkg::GROUP_BITS-1:0] group_a, group_b;
    logic [cwc_pkg::VERDICT_BITS-1:0] step_verdict;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_prec_reg     <= 1'b0;
            unknown_code_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cwc_pkg::CFG_USE_PRECEDENCE:
                begin
                    use_prec_reg <= cfg_data[0];
                end
                cwc_pkg::CFG_UNKNOWN_CODE:
                begin
                    unknown_code_reg <= cfg_data;
                end
            endcase
        end
    end

    // handshake: a result only blocks stage 1 when the result register is full and not drained
    assign s1_produce  = s1_func_reg && s1_ctl_reg.last;
    assign out_free    = !result_valid_reg || result_ready;
    assign s1_go       = !s1_produce || out_free;
    assign s1_fire     = s1_valid_reg && s1_go;
    assign item_ready  = !s1_valid_reg || s1_go;
    assign item_accept = item_valid && item_ready;

    // clamp codes at or above unknown_code, then wrap into the table
    assign clamp_a = (code_a >= CODE_BITS'(unknown_code_reg)) ? unknown_code_reg : code_a[7:0];
    assign clamp_b = (code_b >= CODE_BITS'(unknown_code_reg)) ? unknown_code_reg : code_b[7:0];
    assign rd_addr_a = ADDR_BITS'(clamp_a);
    assign rd_addr_b = ADDR_BITS'(clamp_b);
    assign wr_addr   = ADDR_BITS'(table_index);

    // group table: written by func 0 items, read by compare steps
    cwc_ram #(
        .WIDTH (cwc_pkg::GROUP_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_group_table (
        .clk       (clk),
        .wr_en     (item_accept && !func),
        .wr_addr   (wr_addr),
        .wr_data   (table_group),
        .rd_en     (item_accept && func),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (group_a),
        .rd_data_b (group_b)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // stage 1 payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_func_reg        <= func;
            s1_ctl_reg.has_a   <= has_a;
            s1_ctl_reg.has_b   <= has_b;
            s1_ctl_reg.last    <= last;
            s1_code_a_reg      <= code_a;
            s1_code_b_reg      <= code_b;
        end
    end

    // decision state and verdict for the word pair
    cwc_decide #(
        .CODE_BITS (CODE_BITS)
    ) u_decide (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (s1_fire && s1_func_reg),
        .ctl            (s1_ctl_reg),
        .code_a         (s1_code_a_reg),
        .code_b         (s1_code_b_reg),
        .group_a        (group_a),
        .group_b        (group_b),
        .use_precedence (use_prec_reg),
        .verdict        (step_verdict)
    );

    // result register, refilled in the same cycle it drains
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (s1_fire && s1_produce)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_produce)
        begin
            verdict_reg <= step_verdict;
        end
    end

    assign result_valid = result_valid_reg;
    assign verdict      = verdict_reg;

endmodule

`default_nettype wire

>>> rtl/core/cwc_ram.sv
`default_nettype none

module cwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr_a,
    input  wire logic [ADDR_BITS-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]     rd_data_a,
    output logic      [WIDTH-1:0]     rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/cwc_decide.sv
`default_nettype none

module cwc_decide #(
    parameter int CODE_BITS = cwc_pkg::CODE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                step_en,
    input  wire cwc_pkg::step_ctl_t                  ctl,
    input  wire logic [CODE_BITS-1:0]                code_a,
    input  wire logic [CODE_BITS-1:0]                code_b,
    input  wire logic [cwc_pkg::GROUP_BITS-1:0]      group_a,
    input  wire logic [cwc_pkg::GROUP_BITS-1:0]      group_b,
    input  wire logic                                use_precedence,
    output logic      [cwc_pkg::VERDICT_BITS-1:0]    verdict
);

    logic [cwc_pkg::VERDICT_BITS-1:0] group_dec_reg, group_dec_next;
    logic [cwc_pkg::VERDICT_BITS-1:0] raw_dec_reg, raw_dec_next;
    logic [cwc_pkg::VERDICT_BITS-1:0] len_dec_reg, len_dec_next;
    logic ended_a_reg, ended_a_next;
    logic ended_b_reg, ended_b_next;
    logic [cwc_pkg::VERDICT_BITS-1:0] group_upd, raw_upd, len_upd;
    logic pa, pb;

    // a word that has ended stays absent
    assign pa = ctl.has_a && !ended_a_reg;
    assign pb = ctl.has_b && !ended_b_reg;

    always_comb
    begin
        group_upd = group_dec_reg;
        raw_upd   = raw_dec_reg;
        len_upd   = len_dec_reg;
        if (pa && pb)
        begin
            if (group_dec_reg == cwc_pkg::DEC_EQUAL)
            begin
                group_upd = cwc_pkg::order_code(group_a < group_b, group_a > group_b);
            end
            if (raw_dec_reg == cwc_pkg::DEC_EQUAL)
            begin
                raw_upd = cwc_pkg::order_code(code_a < code_b, code_a > code_b);
            end
        end
        else if (len_dec_reg == cwc_pkg::DEC_EQUAL)
        begin
            len_upd = cwc_pkg::order_code(pb && !pa, pa && !pb);
        end
    end

    // verdict combines the decisions including this step
    always_comb
    begin
        if (use_precedence)
        begin
            if (group_upd != cwc_pkg::DEC_EQUAL)
            begin
                verdict = group_upd;
            end
            else if (len_upd != cwc_pkg::DEC_EQUAL)
            begin
                verdict = len_upd;
            end
            else
            begin
                verdict = raw_upd;
            end
        end
        else if (raw_upd != cwc_pkg::DEC_EQUAL)
        begin
            verdict = raw_upd;
        end
        else
        begin
            verdict = len_upd;
        end
    end

    always_comb
    begin
        group_dec_next = group_dec_reg;
        raw_dec_next   = raw_dec_reg;
        len_dec_next   = len_dec_reg;
        ended_a_next   = ended_a_reg;
        ended_b_next   = ended_b_reg;
        if (step_en)
        begin
            if (ctl.last)
            begin
                // word pair done, back to a clean slate
                group_dec_next = cwc_pkg::DEC_EQUAL;
                raw_dec_next   = cwc_pkg::DEC_EQUAL;
                len_dec_next   = cwc_pkg::DEC_EQUAL;
                ended_a_next   = 1'b0;
                ended_b_next   = 1'b0;
            end
            else
            begin
                group_dec_next = group_upd;
                raw_dec_next   = raw_upd;
                len_dec_next   = len_upd;
                ended_a_next   = ended_a_reg || !pa;
                ended_b_next   = ended_b_reg || !pb;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_dec_reg <= cwc_pkg::DEC_EQUAL;
            raw_dec_reg   <= cwc_pkg::DEC_EQUAL;
            len_dec_reg   <= cwc_pkg::DEC_EQUAL;
            ended_a_reg   <= 1'b0;
            ended_b_reg   <= 1'b0;
        end
        else
        begin
            group_dec_reg <= group_dec_next;
            raw_dec_reg   <= raw_dec_next;
            len_dec_reg   <= len_dec_next;
            ended_a_reg   <= ended_a_next;
            ended_b_reg   <= ended_b_next;
        end
    end

endmodule

`default_nettype wire

>>> sim/tb_collation_word_compare.sv
`timescale 1ns / 1ps

module tb_collation_word_compare;

    localparam int CODE_W      = cwc_pkg::CODE_BITS_DEF;
    localparam int IDX_W       = cwc_pkg::INDEX_BITS;
    localparam int GRP_W       = cwc_pkg::GROUP_BITS;
    localparam int CFG_W       = cwc_pkg::CFG_DATA_BITS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 125;
    localparam int MAX_ROWS    = 32;

    // item opcodes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // one item as the sender sees it
    typedef struct {
        logic              op;
        logic [IDX_W-1:0]  tidx;
        logic [GRP_W-1:0]  tgrp;
        logic [CODE_W-1:0] ca;
        logic              ha;
        logic [CODE_W-1:0] cb;
        logic              hb;
        logic              lst;
    } cmp_item_t;

    // one row of the directed table: either an item or a register setting
    typedef struct {
        bit                               is_cfg;
        cmp_item_t                        it;
        bit                               typed;
        logic [cwc_pkg::VERDICT_BITS-1:0] verdict;
        bit                               prec;
        logic [CFG_W-1:0]                 unk;
    } stim_row_t;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n;

    // configuration channel
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [cwc_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_W-1:0]                   cfg_data;

    // item channel
    logic              item_valid;
    logic              item_ready;
    logic              func;
    logic [IDX_W-1:0]  table_index;
    logic [GRP_W-1:0]  table_group;
    logic [CODE_W-1:0] code_a;
    logic              has_a;
    logic [CODE_W-1:0] code_b;
    logic              has_b;
    logic              last;

    // result channel
    logic                             result_valid;
    logic                             result_ready = 1'b0;
    logic [cwc_pkg::VERDICT_BITS-1:0] verdict;

    // shadow of the block: group table, open decisions, word-end flags, registers
    logic [GRP_W-1:0]                 grp_tbl [256];
    logic [cwc_pkg::VERDICT_BITS-1:0] grp_dec;
    logic [cwc_pkg::VERDICT_BITS-1:0] raw_dec;
    logic [cwc_pkg::VERDICT_BITS-1:0] len_dec;
    bit                               gone_a;
    bit                               gone_b;
    bit                               mode_prec;
    logic [CFG_W-1:0]                 mode_unk;

    // verdicts still owed by the block, oldest first
    logic [cwc_pkg::VERDICT_BITS-1:0] verdict_q [$];
    logic [cwc_pkg::VERDICT_BITS-1:0] want_v;

    stim_row_t   stim_rows [MAX_ROWS];
    int          n_rows;
    int          items_sent;
    int          errors;
    int unsigned cycle_count;
    int unsigned stall_left = 0;
    bit          idle_on;

    collation_word_compare i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .func         (func),
        .table_index  (table_index),
        .table_group  (table_group),
        .code_a       (code_a),
        .has_a        (has_a),
        .code_b       (code_b),
        .has_b        (has_b),
        .last         (last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .verdict      (verdict)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    function automatic logic [cwc_pkg::VERDICT_BITS-1:0] rank_of(input logic [CODE_W-1:0] x,
                                                                 input logic [CODE_W-1:0] y);
        logic [cwc_pkg::VERDICT_BITS-1:0] r;
        if (x < y)
            r = cwc_pkg::DEC_LESS;
        else if (x > y)
            r = cwc_pkg::DEC_GREATER;
        else
            r = cwc_pkg::DEC_EQUAL;
        return r;
    endfunction

    // clamp to the unknown code, then map through the group table
    function automatic logic [GRP_W-1:0] group_of(input logic [CODE_W-1:0] c);
        logic [IDX_W-1:0] idx;
        idx = (c >= CODE_W'(mode_unk)) ? mode_unk : c[IDX_W-1:0];
        return grp_tbl[idx];
    endfunction

    // advance the shadow by one accepted item; gives is set when a verdict is due
    task automatic collate_step(input cmp_item_t it, output bit gives,
                                output logic [cwc_pkg::VERDICT_BITS-1:0] v);
        bit pres_a;
        bit pres_b;
        gives = 1'b0;
        v = cwc_pkg::DEC_EQUAL;
        if (it.op == FUNC_LOAD)
        begin
            // table load leaves the running comparison untouched
            grp_tbl[it.tidx] = it.tgrp;
        end
        else
        begin
            // a word that has ended stays ended until the pair closes
            pres_a = it.ha && !gone_a;
            pres_b = it.hb && !gone_b;
            if (!pres_a)
                gone_a = 1'b1;
            if (!pres_b)
                gone_b = 1'b1;

            if (pres_a && pres_b)
            begin
                if (grp_dec == cwc_pkg::DEC_EQUAL)
                    grp_dec = rank_of(CODE_W'(group_of(it.ca)), CODE_W'(group_of(it.cb)));
                if (raw_dec == cwc_pkg::DEC_EQUAL)
                    raw_dec = rank_of(it.ca, it.cb);
            end
            else if (len_dec == cwc_pkg::DEC_EQUAL)
            begin
                if (pres_a && !pres_b)
                    len_dec = cwc_pkg::DEC_GREATER;
                else if (pres_b && !pres_a)
                    len_dec = cwc_pkg::DEC_LESS;
            end

            if (it.lst)
            begin
                // mode in force at the closing step picks how decisions combine
                gives = 1'b1;
                if (mode_prec)
                begin
                    if (grp_dec != cwc_pkg::DEC_EQUAL)
                        v = grp_dec;
                    else if (len_dec != cwc_pkg::DEC_EQUAL)
                        v = len_dec;
                    else
                        v = raw_dec;
                end
                else
                begin
                    v = (raw_dec != cwc_pkg::DEC_EQUAL) ? raw_dec : len_dec;
                end
                grp_dec = cwc_pkg::DEC_EQUAL;
                raw_dec = cwc_pkg::DEC_EQUAL;
                len_dec = cwc_pkg::DEC_EQUAL;
                gone_a  = 1'b0;
                gone_b  = 1'b0;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // item builders and random content
    // ---------------------------------------------------------------

    function automatic cmp_item_t mk_step(input logic [CODE_W-1:0] ca, input logic ha,
                                          input logic [CODE_W-1:0] cb, input logic hb,
                                          input logic lst);
        cmp_item_t it;
        it.op   = FUNC_STEP;
        it.tidx = IDX_W'($urandom_range(0, 255));
        it.tgrp = GRP_W'($urandom_range(0, 255));
        it.ca   = ca;
        it.ha   = ha;
        it.cb   = cb;
        it.hb   = hb;
        it.lst  = lst;
        return it;
    endfunction

    function automatic cmp_item_t mk_load(input logic [IDX_W-1:0] idx,
                                          input logic [GRP_W-1:0] grp, input logic lst);
        cmp_item_t it;
        it.op   = FUNC_LOAD;
        it.tidx = idx;
        it.tgrp = grp;
        it.ca   = CODE_W'($urandom_range(0, 65535));
        it.ha   = 1'($urandom_range(0, 1));
        it.cb   = CODE_W'($urandom_range(0, 65535));
        it.hb   = 1'($urandom_range(0, 1));
        it.lst  = lst;
        return it;
    endfunction

    // mostly codes around the clamp range, sometimes full width or the extremes
    function automatic logic [CODE_W-1:0] rand_code();
        int pick;
        logic [CODE_W-1:0] c;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            c = CODE_W'($urandom_range(0, 65535));
        else if (pick == 1)
            c = $urandom_range(0, 1) ? '1 : '0;
        else
            c = CODE_W'($urandom_range(0, 300));
        return c;
    endfunction

    function automatic int rand_len();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
    endfunction

    // ---------------------------------------------------------------
    // channel drivers
    // ---------------------------------------------------------------

    // present one item, hold it until taken, then predict its outcome
    task automatic send_item(input cmp_item_t it, input bit typed,
                             input logic [cwc_pkg::VERDICT_BITS-1:0] typed_v);
        bit gives;
        logic [cwc_pkg::VERDICT_BITS-1:0] v;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        item_valid  <= 1'b1;
        func        <= it.op;
        table_index <= it.tidx;
        table_group <= it.tgrp;
        code_a      <= it.ca;
        has_a       <= it.ha;
        code_b      <= it.cb;
        has_b       <= it.hb;
        last        <= it.lst;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
        collate_step(it, gives, v);
        if (gives)
            verdict_q = {verdict_q, (typed ? typed_v : v)};
    endtask

    // both registers, written only once the pipeline has drained
    task automatic write_regs(input bit prec, input logic [CFG_W-1:0] unk);
        item_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        // a step without a result may still be in flight in stage 1
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= cwc_pkg::CFG_USE_PRECEDENCE;
        cfg_data  <= CFG_W'(prec);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mode_prec = prec;
        cfg_index <= cwc_pkg::CFG_UNKNOWN_CODE;
        cfg_data  <= unk;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mode_unk = unk;
        cfg_valid <= 1'b0;
    endtask

    // well-formed word pair: b mostly copies a so that decisions land deep in the words
    task automatic send_word_pair();
        logic [CODE_W-1:0] wa [10];
        logic [CODE_W-1:0] wb [10];
        int len_a;
        int len_b;
        int n_steps;
        len_a = rand_len();
        len_b = ($urandom_range(0, 1) == 0) ? len_a : rand_len();
        for (int k = 0; k < 10; k++)
        begin
            wa[k] = rand_code();
            wb[k] = ($urandom_range(0, 3) != 0) ? wa[k] : rand_code();
        end
        n_steps = ((len_a > len_b) ? len_a : len_b) + $urandom_range(0, 1);
        if (n_steps == 0)
            n_steps = 1;
        for (int s = 0; s < n_steps; s++)
        begin
            // occasional table load in the middle of a pair
            if ($urandom_range(0, 19) == 0)
                send_item(mk_load(IDX_W'($urandom_range(0, 255)),
                                  GRP_W'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1))), 1'b0, cwc_pkg::DEC_EQUAL);
            send_item(mk_step(wa[s], s < len_a, wb[s], s < len_b, s == n_steps - 1),
                      1'b0, cwc_pkg::DEC_EQUAL);
        end
    endtask

    // broken sequences: random table loads, or steps with presence flags and closing bit at random
    task automatic send_noise();
        if ($urandom_range(0, 1) == 0)
            send_item(mk_load(IDX_W'($urandom_range(0, 255)), GRP_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1))), 1'b0, cwc_pkg::DEC_EQUAL);
        else
            send_item(mk_step(rand_code(), 1'($urandom_range(0, 1)), rand_code(),
                              1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0),
                      1'b0, cwc_pkg::DEC_EQUAL);
    endtask

    // ---------------------------------------------------------------
    // directed table
    // ---------------------------------------------------------------

    task automatic add_step(input logic [CODE_W-1:0] ca, input logic ha,
                            input logic [CODE_W-1:0] cb, input logic hb, input logic lst,
                            input bit typed, input logic [cwc_pkg::VERDICT_BITS-1:0] v);
        stim_rows[n_rows].is_cfg  = 1'b0;
        stim_rows[n_rows].it      = mk_step(ca, ha, cb, hb, lst);
        stim_rows[n_rows].typed   = typed;
        stim_rows[n_rows].verdict = v;
        n_rows++;
    endtask

    task automatic add_load(input logic [IDX_W-1:0] idx, input logic [GRP_W-1:0] grp,
                            input logic lst);
        stim_rows[n_rows].is_cfg = 1'b0;
        stim_rows[n_rows].it     = mk_load(idx, grp, lst);
        stim_rows[n_rows].typed  = 1'b0;
        n_rows++;
    endtask

    task automatic add_mode(input bit prec, input logic [CFG_W-1:0] unk);
        stim_rows[n_rows].is_cfg = 1'b1;
        stim_rows[n_rows].prec   = prec;
        stim_rows[n_rows].unk    = unk;
        n_rows++;
    endtask

    task automatic build_directed();
        n_rows = 0;
        // plain code order right after reset: extremes, tie, length, empty words
        add_step(16'h0000, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1, cwc_pkg::DEC_LESS);
        add_step(16'hFFFF, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b1, cwc_pkg::DEC_GREATER);
        add_step(16'h1234, 1'b1, 16'h1234, 1'b1, 1'b1, 1'b1, cwc_pkg::DEC_EQUAL);
        add_step(16'hAAAA, 1'b1, 16'h5555, 1'b0, 1'b1, 1'b1, cwc_pkg::DEC_GREATER);
        add_step(16'h0000, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b1, cwc_pkg::DEC_EQUAL);
        // first word ends, then claims a character again: the claim is ignored
        add_step(16'h0003, 1'b0, 16'h0003, 1'b1, 1'b0, 1'b0, cwc_pkg::DEC_EQUAL);
        add_step(16'h0005, 1'b1, 16'h0005, 1'b1, 1'b1, 1'b1, cwc_pkg::DEC_LESS);
        // table load mid-pair with its closing bit set gives nothing and keeps the pair
        add_step(16'h0007, 1'b1, 16'h0007, 1'b1, 1'b0, 1'b0, cwc_pkg::DEC_EQUAL);
        add_load(8'h80, 8'hFF, 1'b1);
        add_step(16'h0007, 1'b1, 16'h0009, 1'b1, 1'b1, 1'b1, cwc_pkg::DEC_LESS);
        // group order with no clamping, extreme group values
        add_mode(1'b1, 8'hFF);
        add_load(8'h10, 8'h00, 1'b0);
        add_load(8'h20, 8'hFF, 1'b0);
        add_load(8'h30, 8'hFF, 1'b0);
        add_step(16'h0010, 1'b1, 16'h0020, 1'b1, 1'b1, 1'b1, cwc_pkg::DEC_LESS);
        add_step(16'h0020, 1'b1, 16'h0010, 1'b1, 1'b1, 1'b1, cwc_pkg::DEC_GREATER);
        // equal groups: longer first word wins over a smaller raw code
        add_step(16'h0020, 1'b1, 16'h0030, 1'b1, 1'b0, 1'b0, cwc_pkg::DEC_EQUAL);
        add_step(16'h0020, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b1, cwc_pkg::DEC_GREATER);
        // both codes clamp to the same entry, raw order breaks the tie
        add_step(16'hFFFF, 1'b1, 16'h00FF, 1'b1, 1'b1, 1'b0, cwc_pkg::DEC_EQUAL);
        add_mode(1'b1, 8'h10);
        add_step(16'h0010, 1'b1, 16'h9999, 1'b1, 1'b1, 1'b0, cwc_pkg::DEC_EQUAL);
        // mode switched in the middle of a pair
        add_step(16'h0020, 1'b1, 16'h0010, 1'b1, 1'b0, 1'b0, cwc_pkg::DEC_EQUAL);
        add_mode(1'b0, 8'h10);
        add_step(16'h0000, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b0, cwc_pkg::DEC_EQUAL);
    endtask

    // ---------------------------------------------------------------
    // result side: random stalls, checking against the owed verdicts
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            if (stall_left == 1)
                result_ready <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= $urandom_range(1, 9);
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: verdict with none expected: expected none, actual %0d",
                         $time, verdict);
                errors++;
            end
            else
            begin
                want_v = verdict_q.pop_front();
                if (verdict !== want_v)
                begin
                    $display("%0t: verdict mismatch: expected %0d, actual %0d",
                             $time, want_v, verdict);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_collation_word_compare: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin
        int quota;
        int pick;

        // everything known from time zero
        cycle_count = 0;
        errors      = 0;
        items_sent  = 0;
        idle_on     = 1'b1;
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= cwc_pkg::CFG_USE_PRECEDENCE;
        cfg_data    <= '0;
        item_valid  <= 1'b0;
        func        <= FUNC_STEP;
        table_index <= '0;
        table_group <= '0;
        code_a      <= '0;
        has_a       <= 1'b0;
        code_b      <= '0;
        has_b       <= 1'b0;
        last        <= 1'b0;

        // shadow starts at the reset values of the block
        grp_dec   = cwc_pkg::DEC_EQUAL;
        raw_dec   = cwc_pkg::DEC_EQUAL;
        len_dec   = cwc_pkg::DEC_EQUAL;
        gone_a    = 1'b0;
        gone_b    = 1'b0;
        mode_prec = 1'b0;
        mode_unk  = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole group table first so no lookup ever hits an unwritten entry;
        // few distinct groups keep ties common
        for (int i = 0; i < 256; i++)
            send_item(mk_load(IDX_W'(i), GRP_W'($urandom_range(0, 3)),
                              1'($urandom_range(0, 1))), 1'b0, cwc_pkg::DEC_EQUAL);

        // directed table
        build_directed();
        for (int r = 0; r < n_rows; r++)
        begin
            if (stim_rows[r].is_cfg)
                write_regs(stim_rows[r].prec, stim_rows[r].unk);
            else
                send_item(stim_rows[r].it, stim_rows[r].typed, stim_rows[r].verdict);
        end

        // random phases, each under its own register setting; a phase may end
        // with a pair still open, so the next setting lands mid-pair
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_regs(1'b1, 8'hFF);
                1: write_regs(1'b1, 8'h00);
                2: write_regs(1'b0, CFG_W'($urandom_range(1, 254)));
                3: write_regs(1'b1, CFG_W'($urandom_range(16, 200)));
                4: write_regs(1'b1, CFG_W'($urandom_range(1, 254)));
                default: write_regs(1'($urandom_range(0, 1)), CFG_W'($urandom_range(0, 255)));
            endcase
            // one stretch without idling mid-run, and none in the closing phase
            idle_on = (phase != 1) && (phase != 5);
            quota = items_sent + PHASE_ITEMS;
            while (items_sent < quota)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 8)
                    send_word_pair();
                else if (pick == 8)
                    send_item(mk_load(IDX_W'($urandom_range(0, 255)),
                                      GRP_W'($urandom_range(0, 255)),
                                      1'($urandom_range(0, 1))), 1'b0, cwc_pkg::DEC_EQUAL);
                else
                    send_noise();
            end
            if ($urandom_range(0, 1) == 0)
                repeat ($urandom_range(1, 3))
                    send_item(mk_step(rand_code(), 1'b1, rand_code(), 1'b1, 1'b0),
                              1'b0, cwc_pkg::DEC_EQUAL);
        end

        // drain: wait for every owed verdict, then a few cycles for strays
        item_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (errors == 0 && verdict_q.size() == 0)
            $display("tb_collation_word_compare: PASS");
        else
            $display("tb_collation_word_compare: FAIL");
        $finish;
    end

endmodule
